FILE: rtl/ph16_pkg.sv
// ----------------------------------------------------------------------------
// ph16_pkg
// Shared types, widths and the fixed permutation table for the 16-lane
// Pearson hash core.
// ----------------------------------------------------------------------------
package ph16_pkg;

    localparam int BYTE_W    = 8;
    localparam int MAX_LANES = 16;
    localparam int HALF_W    = 64;
    localparam int DIGEST_W  = 2 * HALF_W;
    localparam int TABLE_N   = 256;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [HALF_W-1:0] t_half;

    // fixed 256-entry permutation of the byte values
    localparam t_byte PERM_TABLE [TABLE_N] = '{
        8'd1,   8'd87,  8'd49,  8'd12,  8'd176, 8'd178, 8'd102, 8'd166,
        8'd121, 8'd193, 8'd6,   8'd84,  8'd249, 8'd230, 8'd44,  8'd163,
        8'd14,  8'd197, 8'd213, 8'd181, 8'd161, 8'd85,  8'd218, 8'd80,
        8'd64,  8'd239, 8'd24,  8'd226, 8'd236, 8'd142, 8'd38,  8'd200,
        8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
        8'd77,  8'd101, 8'd81,  8'd18,  8'd45,  8'd96,  8'd31,  8'd222,
        8'd25,  8'd107, 8'd190, 8'd70,  8'd86,  8'd237, 8'd240, 8'd34,
        8'd72,  8'd242, 8'd20,  8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
        8'd97,  8'd234, 8'd57,  8'd22,  8'd60,  8'd250, 8'd82,  8'd175,
        8'd208, 8'd5,   8'd127, 8'd199, 8'd111, 8'd62,  8'd135, 8'd248,
        8'd174, 8'd169, 8'd211, 8'd58,  8'd66,  8'd154, 8'd106, 8'd195,
        8'd245, 8'd171, 8'd17,  8'd187, 8'd182, 8'd179, 8'd0,   8'd243,
        8'd132, 8'd56,  8'd148, 8'd75,  8'd128, 8'd133, 8'd158, 8'd100,
        8'd130, 8'd126, 8'd91,  8'd13,  8'd153, 8'd246, 8'd216, 8'd219,
        8'd119, 8'd68,  8'd223, 8'd78,  8'd83,  8'd88,  8'd201, 8'd99,
        8'd122, 8'd11,  8'd92,  8'd32,  8'd136, 8'd114, 8'd52,  8'd10,
        8'd138, 8'd30,  8'd48,  8'd183, 8'd156, 8'd35,  8'd61,  8'd26,
        8'd143, 8'd74,  8'd251, 8'd94,  8'd129, 8'd162, 8'd63,  8'd152,
        8'd170, 8'd7,   8'd115, 8'd167, 8'd241, 8'd206, 8'd3,   8'd150,
        8'd55,  8'd59,  8'd151, 8'd220, 8'd90,  8'd53,  8'd23,  8'd131,
        8'd125, 8'd173, 8'd15,  8'd238, 8'd79,  8'd95,  8'd89,  8'd16,
        8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37,  8'd123,
        8'd118, 8'd73,  8'd2,   8'd157, 8'd46,  8'd116, 8'd9,   8'd145,
        8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69,  8'd229,
        8'd27,  8'd188, 8'd67,  8'd124, 8'd168, 8'd252, 8'd42,  8'd4,
        8'd29,  8'd108, 8'd21,  8'd247, 8'd19,  8'd205, 8'd39,  8'd203,
        8'd233, 8'd40,  8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
        8'd164, 8'd191, 8'd98,  8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
        8'd140, 8'd36,  8'd210, 8'd172, 8'd41,  8'd54,  8'd159, 8'd8,
        8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47,  8'd146, 8'd120,
        8'd51,  8'd65,  8'd28,  8'd144, 8'd254, 8'd221, 8'd93,  8'd189,
        8'd194, 8'd139, 8'd112, 8'd43,  8'd71,  8'd109, 8'd184, 8'd209
    };

    // one table lookup
    function automatic t_byte perm_lookup(input t_byte idx);
        return PERM_TABLE[idx];
    endfunction

endpackage

FILE: rtl/ph16_in_if.sv
// ----------------------------------------------------------------------------
// ph16_in_if
// Byte stream channel into the hash core: one message byte and a last flag.
// ----------------------------------------------------------------------------
interface ph16_in_if
    import ph16_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/ph16_out_if.sv
// ----------------------------------------------------------------------------
// ph16_out_if
// Digest channel out of the hash core: 128 bits in two 64-bit halves.
// ----------------------------------------------------------------------------
interface ph16_out_if
    import ph16_pkg::*;
();
    logic  valid;
    logic  ready;
    t_half digest_low;
    t_half digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

FILE: rtl/ph16_lane.sv
// ----------------------------------------------------------------------------
// ph16_lane
// Next value of one hash lane: table lookup at (byte + lane index) on the
// first byte of a message, at (lane xor byte) on every later byte.
// ----------------------------------------------------------------------------
module ph16_lane
    import ph16_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  logic  i_start,
    input  t_byte i_data,
    input  t_byte i_lane,
    output t_byte o_next
);

    localparam t_byte LANE_OFS = t_byte'(LANE_IDX);

    t_byte lookup_idx;

    // lookup address, wraps modulo 256
    always_comb begin
        if (i_start) begin
            lookup_idx = i_data + LANE_OFS;
        end else begin
            lookup_idx = i_lane ^ i_data;
        end
    end

    assign o_next = perm_lookup(lookup_idx);

endmodule

FILE: rtl/pearson_hash_16_lane_core.sv
// ----------------------------------------------------------------------------
// pearson_hash_16_lane_core
// Sixteen-lane Pearson hash over a byte stream; emits a 128-bit digest after
// each byte flagged as last.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         request
//  i_in      in   data_byte[7:0], last_byte       one message byte
//  o_out     out  digest_low[63:0], digest_high   one digest per message
//
//  one byte per cycle unless a last byte meets a stalled digest; each lane
//  update is one table lookup between the input and lane registers
//  a digest is registered as its last byte leaves the input register
//  reset (synchronous, active low) clears the lanes and arms message start
//  a stalled digest holds the output register; the byte stage keeps taking
//  bytes until a further last byte needs the output register
// ----------------------------------------------------------------------------
module pearson_hash_16_lane_core
    import ph16_pkg::*;
#(
    parameter int LANES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ph16_in_if.sink    i_in,
    ph16_out_if.source o_out
);

    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;
    logic  r_start;
    t_byte r_lane [LANES];
    t_byte n_lane [LANES];
    logic  r_out_valid;
    t_half r_digest_low;
    t_half r_digest_high;

    logic                stage_take;
    logic [DIGEST_W-1:0] digest_next;

    // byte stage drains unless a last byte finds the output register blocked
    assign stage_take = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || stage_take);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // per-lane lookups and digest packing
    for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
        if (g < LANES) begin : g_on
            ph16_lane #(
                .LANE_IDX (g)
            ) u_lane (
                .i_start (r_start),
                .i_data  (r_in_byte),
                .i_lane  (r_lane[g]),
                .o_next  (n_lane[g])
            );
            assign digest_next[g*BYTE_W +: BYTE_W] = n_lane[g];
        end else begin : g_off
            assign digest_next[g*BYTE_W +: BYTE_W] = '0;
        end
    end

    // lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            for (int k = 0; k < LANES; k++) begin
                r_lane[k] <= '0;
            end
        end else if (stage_take) begin
            r_start <= r_in_last;
            for (int k = 0; k < LANES; k++) begin
                r_lane[k] <= n_lane[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_take && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (stage_take && r_in_last) begin
            r_digest_low  <= digest_next[HALF_W-1:0];
            r_digest_high <= digest_next[DIGEST_W-1:HALF_W];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_low  = r_digest_low;
    assign o_out.digest_high = r_digest_high;

endmodule

FILE: rtl/ph16_check.sv
// ----------------------------------------------------------------------------
// ph16_check
// Port-level checks for the hash core, attached by bind.
// ----------------------------------------------------------------------------
module ph16_check
    import ph16_pkg::*;
#(
    parameter int LANES = 16
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_in_last,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_half i_digest_low,
    input t_half i_digest_high
);

    logic [DIGEST_W-1:0] digest_all;

    assign digest_all = {i_digest_high, i_digest_low};

    // a stalled digest stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("digest dropped while stalled");

    // a stalled digest keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(digest_all))
        else $error("digest changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("digest offered after reset");

    // a new digest must stem from a last byte taken through the input register
    a_digest_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("digest without a last byte");

    // bytes above the active lanes read as zero
    a_idle_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (digest_all >> (BYTE_W * LANES)) == '0)
        else $error("inactive lane byte not zero");

endmodule

bind pearson_hash_16_lane_core ph16_check #(
    .LANES (LANES)
) u_ph16_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last_byte),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_digest_low  (o_out.digest_low),
    .i_digest_high (o_out.digest_high)
);

FILE: tb/sv/pearson_hash_16_lane_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pearson_hash_16_lane_core_tb
// Drives byte streams with last-byte flags into the hash core and checks each
// 128-bit digest against a lane-by-lane software copy of the hash, with
// random gaps on the byte side and random stalls on the digest side.
// ----------------------------------------------------------------------------
module pearson_hash_16_lane_core_tb;
    import ph16_pkg::*;

    localparam int LANES_USED     = 16;
    localparam int DRAIN_CYCLES   = 6;     // digest passes the input and output registers after its last byte
    localparam int WATCHDOG_LIMIT = 2000;  // far above the worst gap + stall + latency
    localparam int RANDOM_BYTES   = 1100;

    typedef struct packed {
        t_half lo;
        t_half hi;
    } t_digest;

    logic i_clk;
    logic i_rst_n;

    ph16_in_if  in_ch ();
    ph16_out_if out_ch ();

    pearson_hash_16_lane_core #(
        .LANES (LANES_USED)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted hash state and the digests still to come
    t_byte   lane_model [MAX_LANES];
    logic    msg_start_model;
    t_digest pending_digests [$];

    int  error_count     = 0;
    int  bytes_sent      = 0;
    int  messages_sent   = 0;
    int  digests_checked = 0;
    int  stall_left      = 0;
    int  idle_cycles     = 0;
    bit  src_idle_en     = 1'b1;
    bit  sink_idle_en    = 1'b1;

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // lane update for one accepted byte; a last byte queues the digest
    function automatic void hash_byte(input t_byte b, input logic last);
        t_digest d;
        t_byte   idx;
        d = '0;
        for (int j = 0; j < LANES_USED; j++) begin
            if (msg_start_model)
                idx = t_byte'(b + j);
            else
                idx = lane_model[j] ^ b;
            lane_model[j] = PERM_TABLE[idx];
        end
        msg_start_model = 1'b0;
        if (last) begin
            for (int j = 0; j < LANES_USED; j++) begin
                if (j < 8)
                    d.lo[8*j +: 8] = lane_model[j];
                else
                    d.hi[8*(j-8) +: 8] = lane_model[j];
            end
            pending_digests.push_back(d);
            msg_start_model = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what, input t_half got, input t_half want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // compare one accepted digest with the oldest pending one
    task automatic check_digest(input t_half lo, input t_half hi);
        t_digest want;
        if (pending_digests.size() == 0) begin
            report_mismatch("digest with no message pending, low half", lo, '0);
            return;
        end
        want = pending_digests.pop_front();
        if (lo !== want.lo)
            report_mismatch("digest_low", lo, want.lo);
        if (hi !== want.hi)
            report_mismatch("digest_high", hi, want.hi);
        digests_checked++;
    endtask

    // digest side: check on handshake, then stall a random number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            check_digest(out_ch.digest_low, out_ch.digest_high);
            stall_left = sink_idle_en ? $urandom_range(0, 15) : 0;
        end else if (out_ch.valid === 1'b1 && stall_left > 0) begin
            stall_left--;
        end
        out_ch.ready <= (stall_left == 0);
    end

    // watchdog on cycles with no request moving on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no request moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // one byte request, after a random gap
    task automatic send_byte(input t_byte b, input logic last);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        hash_byte(b, last);
        bytes_sent++;
        if (last)
            messages_sent++;
    endtask

    task automatic send_random_message(input int len);
        for (int k = 0; k < len; k++)
            send_byte(t_byte'($urandom), k == len - 1);
    endtask

    // hold off the byte side until every digest is back
    task automatic wait_for_digests();
        in_ch.valid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one-byte messages: start-of-message lanes go straight out
    task automatic test_single_byte_messages();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
    endtask

    // byte extremes and alternating patterns inside one message
    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    // lanes kept after a digest must be overwritten by the next first byte
    task automatic test_after_digest();
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
    endtask

    // a run of bytes with no last flag keeps hashing
    task automatic test_long_message();
        for (int k = 0; k < 8; k++)
            send_byte(t_byte'(8'h10 * k + k), 1'b0);
        send_byte(8'h7E, 1'b1);
    endtask

    // no idling on either side, digests back to back
    task automatic test_back_to_back();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int m = 0; m < 6; m++)
            send_random_message($urandom_range(1, 3));
        wait_for_digests();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // heavy digest stalls with short messages so the byte stage backs up
    task automatic test_digest_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        for (int m = 0; m < 8; m++)
            send_random_message($urandom_range(1, 2));
        src_idle_en = 1'b1;
    endtask

    // random messages, mostly short, with the idling mode changed per message
    task automatic test_random_messages();
        int len;
        while (bytes_sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 3))
                0: begin
                    src_idle_en  = 1'b0;
                    sink_idle_en = 1'b0;
                end
                default: begin
                    src_idle_en  = 1'($urandom_range(0, 1));
                    sink_idle_en = 1'($urandom_range(0, 1));
                end
            endcase
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 48);
            else
                len = $urandom_range(1, 12);
            send_random_message(len);
            if ($urandom_range(0, 40) == 0)
                wait_for_digests();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // reset, tests in turn, drain and verdict
    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.last_byte  = 1'b0;
        out_ch.ready     = 1'b0;
        for (int j = 0; j < MAX_LANES; j++)
            lane_model[j] = '0;
        msg_start_model = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte_messages();
        test_byte_extremes();
        test_after_digest();
        test_long_message();
        wait_for_digests();
        test_back_to_back();
        test_digest_backpressure();
        test_random_messages();
        wait_for_digests();

        if (pending_digests.size() != 0) begin
            $display("[%0t] %0d digests never arrived", $time, pending_digests.size());
            error_count++;
        end
        $display("run covered %0d bytes in %0d messages, %0d digests compared",
                 bytes_sent, messages_sent, digests_checked);
        $display("mismatches seen: %0d", error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
